>>> rtl/sorted_priority_task_queue_macros.svh
// assertion helpers for the checker file
`ifndef SORTED_PRIORITY_TASK_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_TASK_QUEUE_MACROS_SVH

// clocked property, disabled while reset is high
`define SPTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define SPTQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `SPTQ_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

>>> rtl/sptq_pkg.sv
`default_nettype none
package sptq_pkg;

   // default sizes
   localparam int DEPTH_DEFAULT         = 16;
   localparam int PRIORITY_BITS_DEFAULT = 8;
   localparam int TAG_BITS_DEFAULT      = 16;

   // request opcodes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // response status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic execute;
   } sptq_cmd_type;

endpackage
`default_nettype wire

>>> rtl/sptq_req_if.sv
`default_nettype none
interface sptq_req_if #(
   parameter int PRIORITY_BITS = sptq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int TAG_BITS      = sptq_pkg::TAG_BITS_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic [PRIORITY_BITS-1:0] task_priority;
   logic [TAG_BITS-1:0]      task_tag;

   modport source (output valid, opcode, task_priority, task_tag, input ready);
   modport sink   (input valid, opcode, task_priority, task_tag, output ready);
endinterface
`default_nettype wire

>>> rtl/sptq_rsp_if.sv
`default_nettype none
interface sptq_rsp_if #(
   parameter int PRIORITY_BITS = sptq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int TAG_BITS      = sptq_pkg::TAG_BITS_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic [PRIORITY_BITS-1:0] out_priority;
   logic [TAG_BITS-1:0]      out_tag;
   logic                     out_valid;
   logic [1:0]               status;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, out_priority, out_tag, out_valid, status, is_empty,
                   is_full, input ready);
   modport sink   (input valid, out_priority, out_tag, out_valid, status, is_empty,
                   is_full, output ready);
endinterface
`default_nettype wire

>>> rtl/sptq_ctrl.sv
`default_nettype none
module sptq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sptq_pkg::sptq_cmd_type     cmd
);
   import sptq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // output register can take a new response
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands to the datapath
   always_comb begin
      cmd.load_req = req_valid && req_ready;
      cmd.execute  = (state_ff == ST_EXEC) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load_req) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.execute) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/sptq_datapath.sv
`default_nettype none
module sptq_datapath #(
   parameter int DEPTH         = sptq_pkg::DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = sptq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int TAG_BITS      = sptq_pkg::TAG_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sptq_pkg::sptq_cmd_type   cmd,
   input  wire logic                     req_opcode,
   input  wire logic [PRIORITY_BITS-1:0] req_priority,
   input  wire logic [TAG_BITS-1:0]      req_tag,
   output logic [PRIORITY_BITS-1:0]      rsp_priority,
   output logic [TAG_BITS-1:0]           rsp_tag,
   output logic                          rsp_out_valid,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full
);
   import sptq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // captured request
   logic                     op_ff;
   logic [PRIORITY_BITS-1:0] pri_ff;
   logic [TAG_BITS-1:0]      tag_ff;

   // sorted entry chain, slot 0 is the front
   logic [PRIORITY_BITS-1:0] ent_pri_ff [DEPTH];
   logic [TAG_BITS-1:0]      ent_tag_ff [DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;

   logic [DEPTH-1:0] stays;
   logic             full, empty, do_enq, do_deq;

   // output register
   logic [PRIORITY_BITS-1:0] out_pri_ff, out_pri_in;
   logic [TAG_BITS-1:0]      out_tag_ff, out_tag_in;
   logic                     out_valid_ff, out_valid_in;
   logic [1:0]               status_ff, status_in;
   logic                     empty_ff, full_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_opcode;
         pri_ff <= req_priority;
         tag_ff <= req_tag;
      end
   end

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign do_enq = cmd.execute && (op_ff == OP_ENQUEUE) && !full;
   assign do_deq = cmd.execute && (op_ff == OP_DEQUEUE) && !empty;

   // per slot: occupied entry that ranks ahead of the new one
   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_slot
         assign stays[i] = (count_ff > CNT_W'(i)) && (ent_pri_ff[i] >= pri_ff);

         // slot update: keep, take new entry, shift back or shift forward
         if (i == 0) begin : g_front
            always_ff @(posedge clock) begin
               if (do_enq && !stays[i]) begin
                  ent_pri_ff[i] <= pri_ff;
                  ent_tag_ff[i] <= tag_ff;
               end else if (do_deq && (DEPTH > 1)) begin
                  ent_pri_ff[i] <= ent_pri_ff[i+1];
                  ent_tag_ff[i] <= ent_tag_ff[i+1];
               end
            end
         end else if (i == DEPTH - 1) begin : g_tail
            always_ff @(posedge clock) begin
               if (do_enq && !stays[i]) begin
                  if (stays[i-1]) begin
                     ent_pri_ff[i] <= pri_ff;
                     ent_tag_ff[i] <= tag_ff;
                  end else begin
                     ent_pri_ff[i] <= ent_pri_ff[i-1];
                     ent_tag_ff[i] <= ent_tag_ff[i-1];
                  end
               end
            end
         end else begin : g_mid
            always_ff @(posedge clock) begin
               if (do_enq && !stays[i]) begin
                  if (stays[i-1]) begin
                     ent_pri_ff[i] <= pri_ff;
                     ent_tag_ff[i] <= tag_ff;
                  end else begin
                     ent_pri_ff[i] <= ent_pri_ff[i-1];
                     ent_tag_ff[i] <= ent_tag_ff[i-1];
                  end
               end else if (do_deq) begin
                  ent_pri_ff[i] <= ent_pri_ff[i+1];
                  ent_tag_ff[i] <= ent_tag_ff[i+1];
               end
            end
         end
      end
   endgenerate

   // fill count
   always_comb begin
      priority if (do_enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_deq) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response fields
   always_comb begin
      out_pri_in   = '0;
      out_tag_in   = '0;
      out_valid_in = 1'b0;
      status_in    = STAT_OK;
      priority if (do_deq) begin
         out_pri_in   = ent_pri_ff[0];
         out_tag_in   = ent_tag_ff[0];
         out_valid_in = 1'b1;
      end else if (op_ff == OP_DEQUEUE) begin
         status_in = STAT_EMPTY;
      end else if (full) begin
         status_in = STAT_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         out_pri_ff   <= out_pri_in;
         out_tag_ff   <= out_tag_in;
         out_valid_ff <= out_valid_in;
         status_ff    <= status_in;
         empty_ff     <= (count_in == '0);
         full_ff      <= (count_in == CNT_W'(DEPTH));
      end
   end

   assign rsp_priority  = out_pri_ff;
   assign rsp_tag       = out_tag_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_is_empty  = empty_ff;
   assign rsp_is_full   = full_ff;
endmodule
`default_nettype wire

>>> rtl/sorted_priority_task_queue.sv
// Sorted priority queue of tasks.
// req channel: opcode (enqueue or dequeue), task_priority, task_tag.
// rsp channel: one response per request with the dequeued priority and tag
// (zero when nothing leaves), out_valid, status (ok, dequeue on empty,
// enqueue on full) and the empty and full flags after the request.
// Entries sit in a chain of registers kept sorted, highest priority at the
// front; equal priorities leave in arrival order. An enqueue compares the new
// priority against every slot at once and shifts the tail back by one slot;
// a dequeue shifts the whole chain forward by one slot.
// The request is registered at the accepting edge; the chain and the output
// register are updated together once the output register is free.
// A new request is taken only after the last one has updated the chain;
// one request is in flight at a time.
// When rsp is stalled the response holds and the pending request waits in
// the update stage until the output register frees up.
// Reset empties the queue (fill count to zero) and drops any response.
`default_nettype none
module sorted_priority_task_queue #(
   parameter int DEPTH         = sptq_pkg::DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = sptq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int TAG_BITS      = sptq_pkg::TAG_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   sptq_req_if.sink  req,
   sptq_rsp_if.source rsp
);
   import sptq_pkg::*;

   sptq_cmd_type cmd;

   // control
   sptq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // entry chain and output register
   sptq_datapath #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .TAG_BITS      (TAG_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_opcode    (req.opcode),
      .req_priority  (req.task_priority),
      .req_tag       (req.task_tag),
      .rsp_priority  (rsp.out_priority),
      .rsp_tag       (rsp.out_tag),
      .rsp_out_valid (rsp.out_valid),
      .rsp_status    (rsp.status),
      .rsp_is_empty  (rsp.is_empty),
      .rsp_is_full   (rsp.is_full)
   );
endmodule
`default_nettype wire

>>> rtl/sptq_checker.sv
`default_nettype none
`include "sorted_priority_task_queue_macros.svh"
module sptq_checker #(
   parameter int PRIORITY_BITS = sptq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int TAG_BITS      = sptq_pkg::TAG_BITS_DEFAULT
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [PRIORITY_BITS-1:0] rsp_out_priority,
   input wire logic [TAG_BITS-1:0]      rsp_out_tag,
   input wire logic                     rsp_out_valid,
   input wire logic [1:0]               rsp_status,
   input wire logic                     rsp_is_empty,
   input wire logic                     rsp_is_full
);
   import sptq_pkg::*;

   // stalled response holds
   `SPTQ_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_priority) &&
      $stable(rsp_out_tag) && $stable(rsp_status),
      "stalled response changed")

   // one request in flight: no request taken right after another
   `SPTQ_ASSERT(a_one_inflight, clock, reset,
      req_valid && req_ready |=> !req_ready,
      "request taken while busy")

   // a dequeued task leaves room and reports ok
   `SPTQ_ASSERT_IMPL(a_deq_ok, clock, reset,
      rsp_valid && rsp_out_valid,
      rsp_status == STAT_OK && !rsp_is_full,
      "dequeue response inconsistent")

   // error responses carry no task and match the flags
   `SPTQ_ASSERT_IMPL(a_err_flags, clock, reset,
      rsp_valid && (rsp_status == STAT_EMPTY || rsp_status == STAT_FULL),
      !rsp_out_valid && rsp_out_priority == '0 && rsp_out_tag == '0 &&
      (rsp_status == STAT_EMPTY ? rsp_is_empty : rsp_is_full),
      "error response inconsistent")
endmodule

bind sorted_priority_task_queue sptq_checker #(
   .PRIORITY_BITS (PRIORITY_BITS),
   .TAG_BITS      (TAG_BITS)
) u_sptq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_out_priority (rsp.out_priority),
   .rsp_out_tag      (rsp.out_tag),
   .rsp_out_valid    (rsp.out_valid),
   .rsp_status       (rsp.status),
   .rsp_is_empty     (rsp.is_empty),
   .rsp_is_full      (rsp.is_full)
);
`default_nettype wire
